>>> src/slso_pkg.sv
// ---------------------------------------------------------------------------
// slso_pkg: shared types and constants of the skip list ordered set
// Operation codes, the queue entry between front and back, engine states and
// the level generator constants.
// ---------------------------------------------------------------------------
package slso_pkg;

  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned FUNC_BITS = 2;

  localparam logic [63:0] LCG_MUL  = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC  = 64'd1442695040888963407;
  localparam logic [63:0] RNG_SEED = 64'h0000_0000_dead_beef;

  typedef enum logic [FUNC_BITS-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // key is stored with its sign bit flipped so an unsigned compare orders it
  typedef struct packed {
    op_e                 op;
    logic [KEY_BITS-1:0] okey;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LINK_REQ, S_LINK_GOT, S_KEY_GOT, S_DECIDE,
    S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_LEVEL, S_POP,
    S_INS_RD, S_INS_W1, S_INS_W2,
    S_DEL_RD, S_DEL_CHK, S_DEL_WR, S_LOWER, S_PUSH, S_RESP
  } state_e;

endpackage

>>> src/slso_req_if.sv
// ---------------------------------------------------------------------------
// slso_req_if: request channel
// Carries one operation code and one signed key per transfer.
// ---------------------------------------------------------------------------
interface slso_req_if;
  logic                                valid;
  logic                                ready;
  logic [slso_pkg::FUNC_BITS-1:0]      func;
  logic signed [slso_pkg::KEY_BITS-1:0] key;

  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

>>> src/slso_rsp_if.sv
// ---------------------------------------------------------------------------
// slso_rsp_if: response channel
// Carries the outcome flags, the key count and the number of levels in use.
// ---------------------------------------------------------------------------
interface slso_rsp_if #(
  parameter int unsigned CNT_W = 11,
  parameter int unsigned TOP_W = 5
);
  logic             valid;
  logic             ready;
  logic             hit;
  logic             pool_full;
  logic [CNT_W-1:0] element_count;
  logic [TOP_W-1:0] top_level;

  modport source (output valid, hit, pool_full, element_count, top_level, input ready);
  modport sink   (input valid, hit, pool_full, element_count, top_level, output ready);
endinterface

>>> src/slso_front.sv
// ---------------------------------------------------------------------------
// slso_front: request intake
// Decodes each request and keeps up to two of them in a small queue for the
// list engine.
// ---------------------------------------------------------------------------
module slso_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  slso_req_if.sink         req_i,
  output logic             q_valid_o,
  output slso_pkg::entry_t q_entry_o,
  input  logic             q_pop_i
);

  slso_pkg::entry_t buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  slso_pkg::entry_t in_entry;

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_entry_o   = buf_q[rd_ptr_q];

  always_comb begin
    in_entry.op   = slso_pkg::op_e'(req_i.func);
    in_entry.okey = req_i.key ^ {1'b1, {(slso_pkg::KEY_BITS-1){1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

>>> src/slso_back.sv
// ---------------------------------------------------------------------------
// slso_back: list engine
// Walks the skip list one link per step, then links in or unlinks a node,
// and holds the response in an output register.
// ---------------------------------------------------------------------------
module slso_back #(
  parameter int unsigned MAX_LEVELS = 16,
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  slso_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  slso_rsp_if.source       rsp_o
);

  localparam int unsigned KB    = slso_pkg::KEY_BITS;
  localparam int unsigned IW    = $clog2(POOL_DEPTH);
  localparam int unsigned NW    = $clog2(POOL_DEPTH + 2);
  localparam int unsigned CW    = $clog2(POOL_DEPTH + 1);
  localparam int unsigned LVW   = $clog2(MAX_LEVELS);
  localparam int unsigned TW    = $clog2(MAX_LEVELS + 1);
  localparam int unsigned AW    = IW + LVW;
  localparam int unsigned LDEP  = POOL_DEPTH * (2 ** LVW);
  localparam logic [NW-1:0] NIL  = NW'(POOL_DEPTH);
  localparam logic [NW-1:0] HEAD = NW'(POOL_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(POOL_DEPTH);

  // storage
  logic [KB-1:0] key_mem  [POOL_DEPTH];
  logic [TW-1:0] lvl_mem  [POOL_DEPTH];
  logic [NW-1:0] link_mem [LDEP];
  logic [IW-1:0] free_mem [POOL_DEPTH];
  logic [NW-1:0] head_q [MAX_LEVELS];
  logic [NW-1:0] upd_q  [MAX_LEVELS];

  slso_pkg::state_e state_q, state_d;
  slso_pkg::op_e    op_q, op_d;
  logic [KB-1:0] key_q, key_d;
  logic [NW-1:0] cur_q, cur_d, nx_q, nx_d, node_q, node_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [TW-1:0] i_q, i_d, newlvl_q, newlvl_d, levels_q, levels_d;
  logic [CW-1:0] kc_q, kc_d, fc_q, fc_d, lw_q, lw_d;
  logic [63:0] rng_q, rng_d, p0_q, p0_d;
  logic [31:0] cr_q, cr_d;
  logic found_q, found_d, fsel_q, fsel_d, hit_q, hit_d, full_q, full_d;

  // memory ports
  logic [NW-1:0] link_rdata, link_wd;
  logic [AW-1:0] link_ra, link_wa;
  logic          link_re, link_we;
  logic [KB-1:0] key_rdata;
  logic [TW-1:0] lvl_rdata;
  logic [IW-1:0] key_ra, key_wa;
  logic          key_re, key_we;
  logic [IW-1:0] free_rdata, free_ra, free_wa, free_wd;
  logic          free_re, free_we;
  logic [LVW-1:0] head_idx, head_wa;
  logic [NW-1:0] head_rd, head_wd, upd_rd;
  logic          head_we, upd_we, upd_fill, uhead;
  logic [NW-1:0] nxv, chk;
  logic [TW-1:0] nl, i_inc, lev_m1;
  logic [CW-1:0] fc_m1;
  logic          run, ld, ld_found, out_load;
  logic [31:0]   s;

  function automatic logic [AW-1:0] link_addr(logic [NW-1:0] node, logic [LVW-1:0] l);
    return {node[IW-1:0], l};
  endfunction

  assign head_rd = head_q[head_idx];
  assign upd_rd  = upd_q[i_q[LVW-1:0]];
  assign uhead   = (upd_rd == HEAD);
  assign i_inc   = i_q + 1'b1;
  assign lev_m1  = levels_q - 1'b1;
  assign fc_m1   = fc_q - 1'b1;
  assign out_load = (state_q == slso_pkg::S_RESP) && (!rsp_o.valid || rsp_o.ready);

  // level of a new node: one plus the run of ones from bit 32, capped
  always_comb begin
    s   = rng_q[63:32];
    nl  = TW'(1);
    run = 1'b1;
    for (int b = 0; b < int'(MAX_LEVELS) - 1; b++) begin
      if (run && s[b]) nl = nl + 1'b1;
      else run = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;  op_d = op_q;  key_d = key_q;
    cur_d = cur_q;  nx_d = nx_q;  node_d = node_q;  lvl_d = lvl_q;
    i_d = i_q;  newlvl_d = newlvl_q;  levels_d = levels_q;
    kc_d = kc_q;  fc_d = fc_q;  lw_d = lw_q;
    rng_d = rng_q;  p0_d = p0_q;  cr_d = cr_q;
    found_d = found_q;  fsel_d = fsel_q;  hit_d = hit_q;  full_d = full_q;
    q_pop_o = 1'b0;
    link_re = 1'b0;  link_ra = link_addr(cur_q, lvl_q);
    link_we = 1'b0;  link_wa = link_addr(node_q, i_q[LVW-1:0]);  link_wd = NIL;
    key_re = 1'b0;  key_ra = nx_q[IW-1:0];
    key_we = 1'b0;  key_wa = node_q[IW-1:0];
    free_re = 1'b0;  free_ra = fc_m1[IW-1:0];
    free_we = 1'b0;  free_wa = fc_q[IW-1:0];  free_wd = node_q[IW-1:0];
    head_idx = i_q[LVW-1:0];
    head_we = 1'b0;  head_wa = i_q[LVW-1:0];  head_wd = node_q;
    upd_we = 1'b0;  upd_fill = 1'b0;
    ld = 1'b0;  ld_found = 1'b0;
    nxv = NIL;  chk = NIL;

    unique case (state_q)
      slso_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          op_d    = q_entry_i.op;
          key_d   = q_entry_i.okey;
          hit_d   = 1'b0;
          full_d  = 1'b0;
          cur_d   = HEAD;
          lvl_d   = lev_m1[LVW-1:0];
          state_d = (q_entry_i.op == slso_pkg::OP_NOP) ? slso_pkg::S_RESP
                                                       : slso_pkg::S_LINK_REQ;
        end
      end
      slso_pkg::S_LINK_REQ: begin
        link_re = 1'b1;
        state_d = slso_pkg::S_LINK_GOT;
      end
      slso_pkg::S_LINK_GOT: begin
        head_idx = lvl_q;
        nxv  = (cur_q == HEAD) ? head_rd : link_rdata;
        nx_d = nxv;
        if (nxv != NIL) begin
          key_re  = 1'b1;
          key_ra  = nxv[IW-1:0];
          state_d = slso_pkg::S_KEY_GOT;
        end else begin
          ld = 1'b1;
        end
      end
      slso_pkg::S_KEY_GOT: begin
        if (key_rdata < key_q) begin
          cur_d   = nx_q;
          state_d = slso_pkg::S_LINK_REQ;
        end else begin
          ld       = 1'b1;
          ld_found = (key_rdata == key_q);
        end
      end
      slso_pkg::S_DECIDE: begin
        state_d = slso_pkg::S_RESP;
        unique case (op_q)
          slso_pkg::OP_SEARCH: hit_d = found_q;
          slso_pkg::OP_INSERT: begin
            if (!found_q) begin
              if (fc_q == '0) full_d = 1'b1;
              else state_d = slso_pkg::S_MUL0;
            end
          end
          slso_pkg::OP_DELETE: begin
            if (found_q) begin
              i_d     = '0;
              node_d  = nx_q;
              state_d = slso_pkg::S_DEL_RD;
            end
          end
          default: ;
        endcase
      end
      // 64-bit generator step, one 32x32 product per cycle
      slso_pkg::S_MUL0: begin
        p0_d    = rng_q[31:0] * slso_pkg::LCG_MUL[31:0];
        state_d = slso_pkg::S_MUL1;
      end
      slso_pkg::S_MUL1: begin
        cr_d    = 32'(rng_q[31:0] * slso_pkg::LCG_MUL[63:32]);
        state_d = slso_pkg::S_MUL2;
      end
      slso_pkg::S_MUL2: begin
        cr_d    = cr_q + 32'(rng_q[63:32] * slso_pkg::LCG_MUL[31:0]);
        state_d = slso_pkg::S_MUL3;
      end
      slso_pkg::S_MUL3: begin
        rng_d   = p0_q + {cr_q, 32'd0} + slso_pkg::LCG_INC;
        state_d = slso_pkg::S_LEVEL;
      end
      slso_pkg::S_LEVEL: begin
        newlvl_d = nl;
        if (nl > levels_q) begin
          upd_fill = 1'b1;
          levels_d = nl;
        end
        fc_d    = fc_m1;
        free_re = 1'b1;
        fsel_d  = (fc_m1 < lw_q);
        if (fc_m1 < lw_q) lw_d = fc_m1;
        state_d = slso_pkg::S_POP;
      end
      slso_pkg::S_POP: begin
        // entries below the low-water mark were never written: slot i holds i
        node_d  = fsel_q ? NW'(fc_q) : NW'(free_rdata);
        key_we  = 1'b1;
        key_wa  = fsel_q ? fc_q[IW-1:0] : free_rdata;
        i_d     = '0;
        state_d = slso_pkg::S_INS_RD;
      end
      slso_pkg::S_INS_RD: begin
        link_re = 1'b1;
        link_ra = link_addr(upd_rd, i_q[LVW-1:0]);
        state_d = slso_pkg::S_INS_W1;
      end
      slso_pkg::S_INS_W1: begin
        link_we = 1'b1;
        link_wd = uhead ? head_rd : link_rdata;
        state_d = slso_pkg::S_INS_W2;
      end
      slso_pkg::S_INS_W2: begin
        if (uhead) head_we = 1'b1;
        else begin
          link_we = 1'b1;
          link_wa = link_addr(upd_rd, i_q[LVW-1:0]);
          link_wd = node_q;
        end
        i_d = i_inc;
        if (i_inc == newlvl_q) begin
          kc_d    = kc_q + 1'b1;
          hit_d   = 1'b1;
          state_d = slso_pkg::S_RESP;
        end else begin
          state_d = slso_pkg::S_INS_RD;
        end
      end
      slso_pkg::S_DEL_RD: begin
        link_re = 1'b1;
        link_ra = link_addr(upd_rd, i_q[LVW-1:0]);
        state_d = slso_pkg::S_DEL_CHK;
      end
      slso_pkg::S_DEL_CHK: begin
        chk = uhead ? head_rd : link_rdata;
        if (chk == node_q) begin
          link_re = 1'b1;
          link_ra = link_addr(node_q, i_q[LVW-1:0]);
          state_d = slso_pkg::S_DEL_WR;
        end else begin
          i_d     = i_inc;
          state_d = (i_inc >= lvl_rdata || i_inc >= levels_q) ? slso_pkg::S_LOWER
                                                              : slso_pkg::S_DEL_RD;
        end
      end
      slso_pkg::S_DEL_WR: begin
        head_wd = link_rdata;
        if (uhead) head_we = 1'b1;
        else begin
          link_we = 1'b1;
          link_wa = link_addr(upd_rd, i_q[LVW-1:0]);
          link_wd = link_rdata;
        end
        i_d     = i_inc;
        state_d = (i_inc >= lvl_rdata || i_inc >= levels_q) ? slso_pkg::S_LOWER
                                                            : slso_pkg::S_DEL_RD;
      end
      slso_pkg::S_LOWER: begin
        head_idx = lev_m1[LVW-1:0];
        if (levels_q > TW'(1) && head_rd == NIL) levels_d = lev_m1;
        else state_d = slso_pkg::S_PUSH;
      end
      slso_pkg::S_PUSH: begin
        if (fc_q < FULL_CNT) begin
          free_we = 1'b1;
          fc_d    = fc_q + 1'b1;
        end
        if (kc_q != '0) kc_d = kc_q - 1'b1;
        hit_d   = 1'b1;
        state_d = slso_pkg::S_RESP;
      end
      slso_pkg::S_RESP: begin
        if (out_load) state_d = slso_pkg::S_IDLE;
      end
      default: state_d = slso_pkg::S_IDLE;
    endcase

    // end of one level of the walk
    if (ld) begin
      upd_we = 1'b1;
      if (lvl_q == '0) begin
        found_d = ld_found;
        state_d = slso_pkg::S_DECIDE;
      end else begin
        lvl_d   = lvl_q - 1'b1;
        state_d = slso_pkg::S_LINK_REQ;
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rdata <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_q;
      lvl_mem[key_wa] <= newlvl_q;
    end
    if (key_re) begin
      key_rdata <= key_mem[key_ra];
      lvl_rdata <= lvl_mem[key_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    if (free_re) free_rdata <= free_mem[free_ra];
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) upd_q[lvl_q] <= cur_q;
    for (int j = 0; j < int'(MAX_LEVELS); j++) begin
      if (upd_fill && TW'(j) >= levels_q && TW'(j) < nl) upd_q[j] <= HEAD;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  key_q <= key_d;  cur_q <= cur_d;  nx_q <= nx_d;
    node_q <= node_d;  lvl_q <= lvl_d;  i_q <= i_d;  newlvl_q <= newlvl_d;
    p0_q <= p0_d;  cr_q <= cr_d;  found_q <= found_d;  fsel_q <= fsel_d;
    hit_q <= hit_d;  full_q <= full_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= slso_pkg::S_IDLE;
      levels_q <= TW'(1);
      kc_q     <= '0;
      fc_q     <= FULL_CNT;
      lw_q     <= FULL_CNT;
      rng_q    <= slso_pkg::RNG_SEED;
      for (int j = 0; j < int'(MAX_LEVELS); j++) head_q[j] <= NIL;
    end else begin
      state_q  <= state_d;
      levels_q <= levels_d;
      kc_q     <= kc_d;
      fc_q     <= fc_d;
      lw_q     <= lw_d;
      rng_q    <= rng_d;
      if (head_we) head_q[head_wa] <= head_wd;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_o.valid <= 1'b0;
    end else if (out_load) begin
      rsp_o.valid <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_o.hit           <= hit_q;
      rsp_o.pool_full     <= full_q;
      rsp_o.element_count <= kc_q;
      rsp_o.top_level     <= levels_q;
    end
  end

endmodule

>>> src/skip_list_ordered_set_core.sv
// ---------------------------------------------------------------------------
// skip_list_ordered_set_core: ordered set of signed keys in a skip list
// Search, insert and delete over a fixed node pool with a free list.
// ---------------------------------------------------------------------------
// Usage:
//   req_i carries func (search, insert, delete; the fourth code does nothing)
//   and key. rsp_o returns one transfer per request: hit, pool_full, the key
//   count and the number of levels in use after the request.
//   Requests enter a two-entry queue, so up to two may be taken while the
//   engine is busy. The engine handles one request at a time.
//   Steps: the engine takes a request from the queue, then walks down from
//   the top level, following links at each level until a null link or a
//   key that is not smaller, then decides. An insert then steps the level
//   generator, pops the free list and links the new node in at each of its
//   levels; a delete unlinks the node at each of its levels, lowers the top
//   level past emptied levels and pushes the node back onto the free list;
//   then the response is loaded. Every step of the walk goes through the
//   single read port of the link memory.
//   Reset empties the set at once: top level 1, count 0, all nodes free.
//   If the receiver stalls, the result waits in the output register and the
//   engine holds; the queue keeps taking requests until it is full.
// ---------------------------------------------------------------------------
module skip_list_ordered_set_core #(
  parameter int unsigned MAX_LEVELS = 16,
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slso_req_if.sink   req_i,
  slso_rsp_if.source rsp_o
);

  logic             q_valid, q_pop;
  slso_pkg::entry_t q_entry;

  slso_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  slso_back #(
    .MAX_LEVELS (MAX_LEVELS),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

  a_full_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.pool_full |-> !rsp_o.hit)
    else $error("pool_full reported together with hit");

  a_top_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.top_level != '0) && (rsp_o.top_level <= MAX_LEVELS))
    else $error("top level out of range");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.element_count <= POOL_DEPTH)
    else $error("element count exceeds pool");

endmodule
